FILE: rtl/core/split_block_bloom_filter_macros.svh
// Assertion macros used by the split block Bloom filter checker.
// Included by files that assert; depends on nothing else.
`ifndef SPLIT_BLOCK_BLOOM_FILTER_MACROS_SVH
`define SPLIT_BLOCK_BLOOM_FILTER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SBBF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SBBF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sbbf_pkg.sv
// Types and constants of the split block Bloom filter.
// Used by the top level, its checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package sbbf_pkg;

  localparam int unsigned WordsPerBlock  = 8;
  localparam int unsigned SlotShift      = 27;
  localparam int unsigned CountLog2Reset = 12;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_QUERY      = 2'd1,
    OP_WRITE_WORD = 2'd2,
    OP_READ_WORD  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [63:0] hash;
    logic [14:0] word_index;
    logic [31:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WORD,
    ST_WAIT,
    ST_DONE
  } state_t;

  function automatic logic [31:0] salt(input logic [2:0] idx);
    logic [31:0] s;
    unique case (idx)
      3'd0: s = 32'h47b6137b;
      3'd1: s = 32'h44974d91;
      3'd2: s = 32'h8824ad5b;
      3'd3: s = 32'ha2b7289d;
      3'd4: s = 32'h705495c7;
      3'd5: s = 32'h2df1424b;
      3'd6: s = 32'h9efc4947;
      3'd7: s = 32'h5c6bfb31;
      default: s = 32'h0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/sbbf_store.sv
// Word store of the split block Bloom filter: one write port and one
// registered read port. Depends on nothing else.
`timescale 1ns / 1ps

module sbbf_store #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/split_block_bloom_filter.sv
// Split block Bloom filter over a 64-bit precomputed hash, with word load and read-back.
// Depends on sbbf_pkg and sbbf_store.
`timescale 1ns / 1ps

// The filter holds MAX_BLOCKS blocks of eight 32-bit words in one memory with one
// word-wide write port and one word-wide read port, which set the pace: an insert or
// query reads one word of its block per cycle in the RUN state and then passes through
// DRAIN and DONE before its result is offered, while a word write or read passes through
// WORD, WAIT and DONE. One item is worked on at a time; a new item is taken while the
// previous result still waits at the output. After reset the store is cleared one word
// per cycle, and no item is accepted then. The block count register may be written only
// while the block is idle.
module split_block_bloom_filter #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [3:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sbbf_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbbf_pkg::out_item_t  out_item
);

  localparam int unsigned StoreWords = MAX_BLOCKS * sbbf_pkg::WordsPerBlock;
  localparam int unsigned AW         = $clog2(StoreWords);
  localparam int unsigned BW         = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NW         = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PW         = 32 + NW;
  localparam int unsigned ResetPow   = 1 << sbbf_pkg::CountLog2Reset;
  localparam int unsigned ResetBlks  = (ResetPow > MAX_BLOCKS) ? MAX_BLOCKS : ResetPow;
  localparam logic [2:0]  LastStep   = 3'(sbbf_pkg::WordsPerBlock - 1);

  sbbf_pkg::state_t    state;
  sbbf_pkg::state_t    state_next;
  logic [AW-1:0]       clear_addr;
  logic [NW-1:0]       blocks;
  logic                pend;
  logic                out_valid_next;

  sbbf_pkg::opcode_t   op;
  logic [31:0]         key;
  logic [BW-1:0]       blk;
  logic [AW-1:0]       word_addr;
  logic                word_ok;
  logic [31:0]         word_value;
  logic [2:0]          step;
  logic [2:0]          step_q;
  logic [4:0]          slot_q;
  logic                found_acc;
  logic [31:0]         rd_value;

  logic                accept;
  logic                out_load;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [31:0]         mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [31:0]         mem_rdata;
  logic [31:0]         mask;
  logic                hit;
  logic [31:0]         salted;
  logic [PW-1:0]       blk_prod;
  logic [31:0]         cfg_pow;
  sbbf_pkg::out_item_t res;

  sbbf_store #(
    .DEPTH (StoreWords),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign accept   = in_valid && in_ready;
  assign blk_prod = PW'(in_item.hash[63:32]) * PW'(blocks);
  assign salted   = key * sbbf_pkg::salt(step);
  assign mask     = 32'(1) << slot_q;
  assign hit      = |(mem_rdata & mask);
  assign cfg_pow  = 32'(1) << cfg_data;

  always_comb begin
    state_next = state;
    unique case (state)
      sbbf_pkg::ST_CLEAR: begin
        if (clear_addr == AW'(StoreWords - 1)) begin
          state_next = sbbf_pkg::ST_IDLE;
        end
      end
      sbbf_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_item.opcode == sbbf_pkg::OP_INSERT || in_item.opcode == sbbf_pkg::OP_QUERY) begin
            state_next = sbbf_pkg::ST_RUN;
          end else begin
            state_next = sbbf_pkg::ST_WORD;
          end
        end
      end
      sbbf_pkg::ST_RUN: begin
        if (step == LastStep) begin
          state_next = sbbf_pkg::ST_DRAIN;
        end
      end
      sbbf_pkg::ST_DRAIN: state_next = sbbf_pkg::ST_DONE;
      sbbf_pkg::ST_WORD:  state_next = sbbf_pkg::ST_WAIT;
      sbbf_pkg::ST_WAIT:  state_next = sbbf_pkg::ST_DONE;
      sbbf_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = sbbf_pkg::ST_IDLE;
        end
      end
      default: state_next = sbbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = word_addr;
    mem_wdata = word_value;
    mem_raddr = word_addr;
    unique case (state)
      sbbf_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = 32'h0;
      end
      sbbf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sbbf_pkg::ST_RUN, sbbf_pkg::ST_DRAIN: begin
        mem_raddr = AW'({blk, step});
        mem_we    = pend && (op == sbbf_pkg::OP_INSERT);
        mem_waddr = AW'({blk, step_q});
        mem_wdata = mem_rdata | mask;
      end
      sbbf_pkg::ST_WORD: begin
        mem_we = word_ok && (op == sbbf_pkg::OP_WRITE_WORD);
      end
      sbbf_pkg::ST_WAIT: begin
      end
      sbbf_pkg::ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_next = out_load || (out_valid && !out_ready);

  always_comb begin
    res.found      = (op == sbbf_pkg::OP_QUERY) && found_acc;
    res.read_value = rd_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sbbf_pkg::ST_CLEAR;
      clear_addr <= '0;
      blocks     <= NW'(ResetBlks);
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= (state == sbbf_pkg::ST_RUN);
      out_valid <= out_valid_next;
      if (state == sbbf_pkg::ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (cfg_write) begin
        blocks <= (cfg_pow > 32'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(cfg_pow);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= in_item.opcode;
      key        <= in_item.hash[31:0];
      blk        <= blk_prod[32 +: BW];
      word_addr  <= AW'(in_item.word_index);
      word_ok    <= 32'(in_item.word_index) < 32'(StoreWords);
      word_value <= in_item.word_value;
      step       <= 3'd0;
      found_acc  <= 1'b1;
      rd_value   <= 32'h0;
    end
    if (state == sbbf_pkg::ST_RUN) begin
      step   <= step + 3'd1;
      step_q <= step;
      slot_q <= 5'(salted >> sbbf_pkg::SlotShift);
    end
    if (pend && op == sbbf_pkg::OP_QUERY && !hit) begin
      found_acc <= 1'b0;
    end
    if (state == sbbf_pkg::ST_WAIT) begin
      rd_value <= (op == sbbf_pkg::OP_READ_WORD && word_ok) ? mem_rdata : 32'h0;
    end
    if (out_load) begin
      out_item <= res;
    end
  end

endmodule

FILE: rtl/core/sbbf_checker.sv
// Port-level checks of the split block Bloom filter, bound to the top level.
// Depends on sbbf_pkg and split_block_bloom_filter_macros.svh.
`timescale 1ns / 1ps
`include "split_block_bloom_filter_macros.svh"

module sbbf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sbbf_pkg::out_item_t out_item
);

  `SBBF_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item), "stalled result item changed")
  `SBBF_ASSERT(a_fields_excl, clk, rst, out_valid |-> !(out_item.found && out_item.read_value != 32'h0), "found and read value both set")
  `SBBF_ASSERT_ALWAYS(a_clear_after_rst, clk, rst |=> !in_ready, "item taken during clearing pass")
  `SBBF_ASSERT(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready && !$rose(out_valid), "item taken or result shown right after an accept")

endmodule

bind split_block_bloom_filter sbbf_checker u_sbbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

FILE: sim/split_block_bloom_filter_tb.sv
// Self-checking testbench for split_block_bloom_filter: directed items, then random
// phases at several block counts, checked against given results or a shadow copy of the filter words.
// Depends on sbbf_pkg and the split_block_bloom_filter RTL.
`timescale 1ns / 1ps

module split_block_bloom_filter_tb;
  import sbbf_pkg::*;

  localparam int unsigned MAX_BLOCKS = 4096;
  localparam int unsigned STORE_WORDS = MAX_BLOCKS * WordsPerBlock;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned NUM_DIRECTED = 18;
  localparam int unsigned PHASES = 7;
  localparam int unsigned ITEMS_PER_PHASE = 170;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned IDLE_PCT = 12;
  localparam logic [7:0][31:0] SALTS = {
    32'h5c6bfb31, 32'h9efc4947, 32'h2df1424b, 32'h705495c7,
    32'ha2b7289d, 32'h8824ad5b, 32'h44974d91, 32'h47b6137b
  };
  localparam logic [PHASES-1:0][3:0] PHASE_LOG2 = {
    4'd12, 4'd6, 4'd13, 4'd1, 4'd15, 4'd0, 4'd12
  };

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      cfg_write;
  logic [3:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  logic [31:0] shadow_words [STORE_WORDS];
  logic [3:0]  shadow_log2;
  out_item_t   results_due [$];
  logic [63:0] inserted_hashes [$];
  stim_row_t   directed_rows [NUM_DIRECTED];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = IDLE_PCT;
  int unsigned hold_pct = IDLE_PCT;
  int unsigned hold_left = 0;
  bit          want_long_hold = 1'b0;

  split_block_bloom_filter #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stim_row_t mk_row(input opcode_t op, input logic [63:0] h,
                                       input logic [14:0] idx, input logic [31:0] v,
                                       input bit typed, input logic f,
                                       input logic [31:0] rd);
    stim_row_t row;
    row.item.opcode = op;
    row.item.hash = h;
    row.item.word_index = idx;
    row.item.word_value = v;
    row.typed = typed;
    row.result.found = f;
    row.result.read_value = rd;
    return row;
  endfunction

  function automatic int unsigned active_block_count();
    int unsigned blocks;
    blocks = 1 << shadow_log2;
    if (blocks > MAX_BLOCKS) begin
      blocks = MAX_BLOCKS;
    end
    return blocks;
  endfunction

  // Applies one item to the shadow filter and returns the result it should produce.
  function automatic out_item_t predict_filter_result(input in_item_t it);
    out_item_t   res;
    logic [63:0] blocks64;
    logic [63:0] scaled;
    logic [31:0] mixed;
    logic [31:0] mask;
    int unsigned base;
    int          i;
    bit          all_set;
    res = '0;
    case (it.opcode)
      OP_INSERT, OP_QUERY: begin
        blocks64 = 64'(active_block_count());
        scaled = {32'd0, it.hash[63:32]} * blocks64;
        base = scaled[63:32] * WordsPerBlock;
        all_set = 1'b1;
        for (i = 0; i < WordsPerBlock; i++) begin
          mixed = it.hash[31:0] * SALTS[i];
          mask = 32'd1 << (mixed >> SlotShift);
          if (it.opcode == OP_INSERT) begin
            shadow_words[base + i] = shadow_words[base + i] | mask;
          end else if ((shadow_words[base + i] & mask) == '0) begin
            all_set = 1'b0;
          end
        end
        res.found = (it.opcode == OP_QUERY) && all_set;
      end
      OP_WRITE_WORD: begin
        if (it.word_index < STORE_WORDS) begin
          shadow_words[it.word_index] = it.word_value;
        end
      end
      default: begin
        if (it.word_index < STORE_WORDS) begin
          res.read_value = shadow_words[it.word_index];
        end
      end
    endcase
    return res;
  endfunction

  // Most queries look up a hash inserted earlier in the same phase so that hits are common.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned words;
    it.opcode = opcode_t'($urandom_range(3));
    it.hash = {$urandom, $urandom};
    it.word_index = 15'($urandom);
    it.word_value = $urandom;
    words = active_block_count() * WordsPerBlock;
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.opcode = OP_INSERT;
      inserted_hashes.push_back(it.hash);
      if (inserted_hashes.size() > 64) begin
        void'(inserted_hashes.pop_front());
      end
    end else if (pick < 60 && inserted_hashes.size() != 0) begin
      it.opcode = OP_QUERY;
      it.hash = inserted_hashes[$urandom_range(inserted_hashes.size() - 1)];
    end else if (pick < 72) begin
      it.opcode = OP_QUERY;
    end else if (pick < 86) begin
      it.opcode = OP_WRITE_WORD;
      if ($urandom_range(1) == 1) begin
        it.word_index = 15'($urandom_range(words - 1));
      end
      case ($urandom_range(3))
        0: it.word_value = '0;
        1: it.word_value = '1;
        default: begin
        end
      endcase
    end else begin
      it.opcode = OP_READ_WORD;
      if ($urandom_range(1) == 1) begin
        it.word_index = 15'($urandom_range(words - 1));
      end
    end
    return it;
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      $error("unexpected result: found %0d read_value %h", got.found, got.read_value);
      fail_count++;
      return;
    end
    want = results_due.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      fail_count++;
    end
    if (got.read_value !== want.read_value) begin
      $error("read_value: expected %h, got %h", want.read_value, got.read_value);
      fail_count++;
    end
  endfunction

  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t typed_result);
    out_item_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) begin
      @(posedge clk);
    end
    predicted = predict_filter_result(it);
    results_due.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_block_count_log2(input logic [3:0] value);
    @(posedge clk);
    while (in_ready !== 1'b1) begin
      @(posedge clk);
    end
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_log2 = value;
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        check_result(out_item);
      end
      if (want_long_hold) begin
        want_long_hold = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= hold_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned p;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_item <= '0;
    shadow_log2 = 4'(CountLog2Reset);
    foreach (shadow_words[k]) begin
      shadow_words[k] = '0;
    end
    directed_rows = '{
      mk_row(OP_READ_WORD, 64'h0, 15'h0, 32'h0, 1'b1, 1'b0, 32'h0),
      mk_row(OP_READ_WORD, 64'h0, 15'h7fff, 32'h0, 1'b1, 1'b0, 32'h0),
      mk_row(OP_QUERY, 64'h0, 15'h0, 32'h0, 1'b1, 1'b0, 32'h0),
      mk_row(OP_QUERY, 64'hffff_ffff_ffff_ffff, 15'h0, 32'h0, 1'b1, 1'b0, 32'h0),
      mk_row(OP_INSERT, 64'h0, 15'h7fff, 32'hffff_ffff, 1'b1, 1'b0, 32'h0),
      mk_row(OP_QUERY, 64'h0, 15'h0, 32'h0, 1'b1, 1'b1, 32'h0),
      mk_row(OP_READ_WORD, 64'hffff_ffff_ffff_ffff, 15'h0, 32'hffff_ffff, 1'b0, 1'b0, 32'h0),
      mk_row(OP_INSERT, 64'hffff_ffff_ffff_ffff, 15'h0, 32'h0, 1'b1, 1'b0, 32'h0),
      mk_row(OP_QUERY, 64'hffff_ffff_ffff_ffff, 15'h7fff, 32'hffff_ffff, 1'b1, 1'b1, 32'h0),
      mk_row(OP_WRITE_WORD, 64'hffff_ffff_ffff_ffff, 15'h7fff, 32'hffff_ffff, 1'b1, 1'b0, 32'h0),
      mk_row(OP_READ_WORD, 64'h0, 15'h7fff, 32'h0, 1'b1, 1'b0, 32'hffff_ffff),
      mk_row(OP_WRITE_WORD, 64'h0, 15'h0, 32'h0, 1'b1, 1'b0, 32'h0),
      mk_row(OP_QUERY, 64'h0, 15'h0, 32'h0, 1'b0, 1'b0, 32'h0),
      mk_row(OP_WRITE_WORD, 64'h0, 15'h5, 32'ha5a5_a5a5, 1'b1, 1'b0, 32'h0),
      mk_row(OP_READ_WORD, 64'h0, 15'h5, 32'h0, 1'b1, 1'b0, 32'ha5a5_a5a5),
      mk_row(OP_INSERT, 64'h0123_4567_89ab_cdef, 15'h2aaa, 32'h5555_aaaa, 1'b1, 1'b0, 32'h0),
      mk_row(OP_QUERY, 64'h0123_4567_89ab_cdef, 15'h0, 32'h0, 1'b1, 1'b1, 32'h0),
      mk_row(OP_QUERY, 64'hfedc_ba98_7654_3210, 15'h0, 32'h0, 1'b0, 1'b0, 32'h0)
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < NUM_DIRECTED; n++) begin
      offer_item(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].result);
    end

    // Phase 2 runs without idling on either side; phase 3 stalls the output for a long
    // stretch so the input backs up; phase 4 pauses the input until all results are back.
    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain_results();
        write_block_count_log2(PHASE_LOG2[p]);
      end
      inserted_hashes.delete();
      send_gap_pct = (p == 2) ? 0 : IDLE_PCT;
      hold_pct = (p == 2) ? 0 : IDLE_PCT;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == 40) begin
          want_long_hold = 1'b1;
        end
        if (p == 4 && n == ITEMS_PER_PHASE / 2) begin
          drain_results();
        end
        offer_item(random_item(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
